// ===== sv/polar_gaussian_sample_generator_top_macros.svh =====
// Assertion macros shared by the polar Gaussian sample generator RTL.
`ifndef POLAR_GAUSSIAN_SAMPLE_GENERATOR_TOP_MACROS_SVH
`define POLAR_GAUSSIAN_SAMPLE_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst is high.
`define PGSG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pgsg same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst is high.
`define PGSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pgsg next-cycle check failed");
`else
`define PGSG_ASSERT_NOW(lbl, ante, cons)
`define PGSG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/pgsg_pkg.sv =====
// Types and constants of the polar Gaussian sample generator.
package pgsg_pkg;

  // Fraction bits of the log, t and z values.
  localparam int unsigned ZF = 26;
  // round(2 ln 2 * 2^30).
  localparam logic [31:0] LN2X2_Q30 = 32'd1488522236;
  localparam logic [31:0] MEAN_RESET = 32'h0000_0000;
  localparam logic [31:0] STD_DEV_RESET = 32'h0001_0000;
  // One root bit per stage for a 64-bit radicand.
  localparam int unsigned SQRT_STEPS = 32;
  // One quotient bit per stage, 31 quotient bits.
  localparam int unsigned DIV_STEPS = 31;

  typedef enum logic [0:0] {
    REG_MEAN_OFFSET = 1'b0,
    REG_STD_DEV     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] uniform_a;
    logic [31:0] uniform_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } out_beat_t;

  // Pipeline advance and the valid bit entering a unit.
  typedef struct packed {
    logic adv;
    logic valid;
  } stage_ctl_t;

endpackage

// ===== sv/pgsg_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit resolved per stage.
module pgsg_sqrt_pipe (
  input  logic                clk,
  input  logic                rst,
  input  pgsg_pkg::stage_ctl_t ctl,
  input  logic [63:0]         radicand,
  output logic                root_valid,
  output logic [31:0]         root
);

  localparam int unsigned N = pgsg_pkg::SQRT_STEPS;

  logic [33:0] rem_q  [0:N-1];
  logic [31:0] root_q [0:N-1];
  logic [63:0] x_q    [0:N-1];
  logic        vld_q  [0:N-1];

  logic [33:0] rem_next  [0:N-1];
  logic [31:0] root_next [0:N-1];
  logic [63:0] x_next    [0:N-1];

  always_comb begin
    logic [33:0] pr;
    logic [31:0] pt;
    logic [63:0] px;
    logic [35:0] wide;
    logic [35:0] trial;
    logic        ge;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        pr = '0;
        pt = '0;
        px = radicand;
      end else begin
        pr = rem_q[k-1];
        pt = root_q[k-1];
        px = x_q[k-1];
      end
      wide  = {pr, px[63:62]};
      trial = {2'b00, pt, 2'b01};
      ge    = (wide >= trial);
      rem_next[k]  = ge ? 34'(wide - trial) : wide[33:0];
      root_next[k] = {pt[30:0], ge};
      x_next[k]    = {px[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
        x_q[k]    <= x_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (ctl.adv) begin
      vld_q[0] <= ctl.valid;
      for (int k = 1; k < N; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign root_valid = vld_q[N-1];
  assign root       = root_q[N-1];

endmodule

// ===== sv/pgsg_div_pipe.sv =====
// Pipelined restoring divider for num * 2^30 / den with num <= den.
module pgsg_div_pipe (
  input  logic                clk,
  input  logic                rst,
  input  pgsg_pkg::stage_ctl_t ctl,
  input  logic [31:0]         num,
  input  logic [31:0]         den,
  output logic                quo_valid,
  output logic [30:0]         quo
);

  localparam int unsigned N = pgsg_pkg::DIV_STEPS;

  logic [31:0] rem_q [0:N-1];
  logic [31:0] den_q [0:N-1];
  logic [30:0] quo_q [0:N-1];
  logic        vld_q [0:N-1];

  logic [31:0] rem_next [0:N-1];
  logic [31:0] den_next [0:N-1];
  logic [30:0] quo_next [0:N-1];

  // The first stage resolves the top quotient bit without a shift, the
  // others shift the partial remainder left by one before the compare.
  always_comb begin
    logic [32:0] r2;
    logic [31:0] pd;
    logic [30:0] pq;
    logic        ge;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        r2 = {1'b0, num};
        pd = den;
        pq = '0;
      end else begin
        r2 = {rem_q[k-1], 1'b0};
        pd = den_q[k-1];
        pq = quo_q[k-1];
      end
      ge = (r2 >= {1'b0, pd});
      rem_next[k] = ge ? 32'(r2 - {1'b0, pd}) : r2[31:0];
      den_next[k] = pd;
      quo_next[k] = {pq[29:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= rem_next[k];
        den_q[k] <= den_next[k];
        quo_q[k] <= quo_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (ctl.adv) begin
      vld_q[0] <= ctl.valid;
      for (int k = 1; k < N; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign quo_valid = vld_q[N-1];
  assign quo       = quo_q[N-1];

endmodule

// ===== sv/polar_gaussian_sample_generator_top.sv =====
// Top level of the polar-method Gaussian sample generator pipeline.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+------------------------------
//   input     | in_valid / in_ready          | in_data: uniform_a, uniform_b
//   output    | out_valid / out_ready        | out_data: sample, last
//   config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// A uniform pair enters the pipeline in any cycle in which in_ready is high, one pair
// per cycle. A kept pair gives two output beats, and the pipeline depth is set
// by the 26 log squarings with the one-bit-per-stage square root after them,
// matched by the square root of r and the divider. A rejected pair leaves no beat.
// Each kept pair needs two output beats, and the output sends one beat per
// cycle while out_ready is high. Reset clears all valid bits and loads the
// register defaults; there is no clearing pass. When the output is stalled
// the whole pipeline holds, unless its last stage is empty.
`include "polar_gaussian_sample_generator_top_macros.svh"

module polar_gaussian_sample_generator_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pgsg_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pgsg_pkg::out_beat_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Magnitudes and signs of v1 and v2 that ride along the pipeline.
  typedef struct packed {
    logic [31:0] m1;
    logic [31:0] m2;
    logic        n1;
    logic        n2;
  } side_t;

  localparam int unsigned ZF = pgsg_pkg::ZF;

  // ---------------------------------------------------------------------
  // Configuration registers. The register index is paddr[2]; the low
  // address bits select nothing.
  // ---------------------------------------------------------------------
  logic signed [31:0] mean_offset;
  logic        [31:0] std_dev;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_offset <= pgsg_pkg::MEAN_RESET;
      std_dev     <= pgsg_pkg::STD_DEV_RESET;
    end else if (cfg_wr) begin
      unique case (pgsg_pkg::reg_idx_t'(paddr[2]))
        pgsg_pkg::REG_MEAN_OFFSET: mean_offset <= pwdata;
        pgsg_pkg::REG_STD_DEV:     std_dev     <= pwdata;
        default:                   std_dev     <= std_dev;
      endcase
    end
  end

  always_comb begin
    unique case (pgsg_pkg::reg_idx_t'(paddr[2]))
      pgsg_pkg::REG_MEAN_OFFSET: prdata = mean_offset;
      pgsg_pkg::REG_STD_DEV:     prdata = std_dev;
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Global advance. Every stage moves together; the pipeline only holds
  // when its last stage is full and the output register cannot take it.
  // ---------------------------------------------------------------------
  logic adv;
  logic q4_v;
  logic hold_v;
  logic hold_phase;
  logic hold_release;
  logic hold_load;

  assign hold_release = hold_v & hold_phase & out_ready;
  assign hold_load    = q4_v & (~hold_v | hold_release);
  assign adv          = ~q4_v | hold_load;
  assign in_ready     = adv;

  function automatic logic [31:0] v_mag(input logic [31:0] u);
    // |2u - 1| in Q.31: u - 1/2 when u is at least a half, else 1/2 - u.
    v_mag = u[31] ? {1'b0, u[30:0]} : (32'h8000_0000 - u);
  endfunction

  function automatic logic [31:0] sat32(input logic [39:0] s);
    logic [8:0] top;
    top = s[39:31];
    if (top == 9'h000 || top == 9'h1FF) begin
      sat32 = s[31:0];
    end else if (s[39]) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = 32'h7FFF_FFFF;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Front end: v from u, the two squares, and the sum r with the reject test.
  // ---------------------------------------------------------------------
  side_t       p1_sd, p2_sd, p3_sd;
  logic        p1_v, p2_v, p3_v;
  logic [63:0] p2_sq1, p2_sq2;
  logic [61:0] p3_rr;
  logic [63:0] rr_sum;
  logic        rr_ok;

  assign rr_sum = p2_sq1 + p2_sq2;
  // A pair is kept only when 0 < r < 1.
  assign rr_ok  = (rr_sum != 64'd0) && (rr_sum[63:62] == 2'b00);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_sd.m1 <= v_mag(in_data.uniform_a);
      p1_sd.m2 <= v_mag(in_data.uniform_b);
      p1_sd.n1 <= ~in_data.uniform_a[31];
      p1_sd.n2 <= ~in_data.uniform_b[31];
      p2_sd    <= p1_sd;
      p2_sq1   <= {32'd0, p1_sd.m1} * {32'd0, p1_sd.m1};
      p2_sq2   <= {32'd0, p1_sd.m2} * {32'd0, p1_sd.m2};
      p3_sd    <= p2_sd;
      p3_rr    <= rr_sum[61:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else if (adv) begin
      p1_v <= in_valid;
      p2_v <= p1_v;
      p3_v <= p2_v & rr_ok;
    end
  end

  // ---------------------------------------------------------------------
  // -log2(r): leading-one search over two stages, normalization to Q1.30,
  // then one squaring per stage for each of the 26 fraction bits.
  // ---------------------------------------------------------------------
  logic [63:0] rr64;
  logic [1:0]  l1_idx_next;
  logic [63:0] l1_rr;
  logic [1:0]  l1_idx;
  logic        l1_v;
  logic [15:0] l1_chunk;
  logic [3:0]  l2_pos_next;
  logic [63:0] l2_rr;
  logic [5:0]  l2_p;
  logic        l2_v;
  logic [63:0] l2_sh;
  logic [30:0] l3_m;
  logic [5:0]  l3_p;
  logic        l3_v;

  assign rr64 = {2'b00, p3_rr};

  always_comb begin
    l1_idx_next = '0;
    for (int i = 0; i < 4; i++) begin
      if (rr64[16*i +: 16] != 16'd0) begin
        l1_idx_next = 2'(i);
      end
    end
  end

  assign l1_chunk = l1_rr[{l1_idx, 4'd0} +: 16];

  always_comb begin
    l2_pos_next = '0;
    for (int j = 0; j < 16; j++) begin
      if (l1_chunk[j]) begin
        l2_pos_next = 4'(j);
      end
    end
  end

  always_comb begin
    if (l2_p >= 6'd30) begin
      l2_sh = l2_rr >> (l2_p - 6'd30);
    end else begin
      l2_sh = l2_rr << (6'd30 - l2_p);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_rr  <= rr64;
      l1_idx <= l1_idx_next;
      l2_rr  <= l1_rr;
      l2_p   <= {l1_idx, l2_pos_next};
      l3_m   <= l2_sh[30:0];
      l3_p   <= l2_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_v <= 1'b0;
      l2_v <= 1'b0;
      l3_v <= 1'b0;
    end else if (adv) begin
      l1_v <= p3_v;
      l2_v <= l1_v;
      l3_v <= l2_v;
    end
  end

  localparam int unsigned NSQ = ZF;

  logic [30:0]   sq_m [0:NSQ-1];
  logic [ZF-1:0] sq_f [0:NSQ-1];
  logic [5:0]    sq_p [0:NSQ-1];
  logic          sq_v [0:NSQ-1];
  logic [30:0]   sq_m_next [0:NSQ-1];
  logic [ZF-1:0] sq_f_next [0:NSQ-1];
  logic [5:0]    sq_p_next [0:NSQ-1];

  // Each stage squares the Q1.30 mantissa; a result of two or more gives a
  // one in the fraction and is halved back into range.
  always_comb begin
    logic [30:0]   pm;
    logic [ZF-1:0] pf;
    logic [5:0]    pp;
    logic [61:0]   prod;
    logic [31:0]   sq;
    for (int k = 0; k < NSQ; k++) begin
      if (k == 0) begin
        pm = l3_m;
        pf = '0;
        pp = l3_p;
      end else begin
        pm = sq_m[k-1];
        pf = sq_f[k-1];
        pp = sq_p[k-1];
      end
      prod = {31'd0, pm} * {31'd0, pm};
      sq   = prod[61:30];
      sq_m_next[k] = sq[31] ? sq[31:1] : sq[30:0];
      sq_f_next[k] = {pf[ZF-2:0], sq[31]};
      sq_p_next[k] = pp;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NSQ; k++) begin
        sq_m[k] <= sq_m_next[k];
        sq_f[k] <= sq_f_next[k];
        sq_p[k] <= sq_p_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSQ; k++) begin
        sq_v[k] <= 1'b0;
      end
    end else if (adv) begin
      sq_v[0] <= l3_v;
      for (int k = 1; k < NSQ; k++) begin
        sq_v[k] <= sq_v[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // t = -2 ln r = (-log2 r) * 2 ln 2, Q.26, then g = sqrt(t) in Q.26.
  // ---------------------------------------------------------------------
  logic [31:0] ln_l;
  logic        ln_v;
  logic [63:0] t_prod;
  logic [32:0] t_q;
  logic        t_v;

  assign t_prod = {32'd0, ln_l} * {32'd0, pgsg_pkg::LN2X2_Q30};

  always_ff @(posedge clk) begin
    if (adv) begin
      ln_l <= {6'd62 - sq_p[NSQ-1], {ZF{1'b0}}} - {6'd0, sq_f[NSQ-1]};
      t_q  <= t_prod[62:30];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ln_v <= 1'b0;
      t_v  <= 1'b0;
    end else if (adv) begin
      ln_v <= sq_v[NSQ-1];
      t_v  <= ln_v;
    end
  end

  logic        g_vld;
  logic [31:0] g_root;

  pgsg_sqrt_pipe u_sqrt_g (
    .clk        (clk),
    .rst        (rst),
    .ctl        ('{adv: adv, valid: t_v}),
    .radicand   ({5'd0, t_q, {ZF{1'b0}}}),
    .root_valid (g_vld),
    .root       (g_root)
  );

  // ---------------------------------------------------------------------
  // sqrt(r) in parallel with the log, then c = |v| / sqrt(r) in Q.30 for
  // both samples. The side data follows in delay lines of matching length.
  // ---------------------------------------------------------------------
  logic        rr_vld;
  logic [31:0] rr_root;

  pgsg_sqrt_pipe u_sqrt_rr (
    .clk        (clk),
    .rst        (rst),
    .ctl        ('{adv: adv, valid: p3_v}),
    .radicand   (rr64),
    .root_valid (rr_vld),
    .root       (rr_root)
  );

  localparam int unsigned NSB = pgsg_pkg::SQRT_STEPS;
  localparam int unsigned NNG = pgsg_pkg::DIV_STEPS;

  side_t      sb [0:NSB-1];
  logic [1:0] ng [0:NNG-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= p3_sd;
      for (int k = 1; k < NSB; k++) begin
        sb[k] <= sb[k-1];
      end
      ng[0] <= {sb[NSB-1].n1, sb[NSB-1].n2};
      for (int k = 1; k < NNG; k++) begin
        ng[k] <= ng[k-1];
      end
    end
  end

  logic        div1_vld, div2_vld;
  logic [30:0] c1, c2;

  pgsg_div_pipe u_div_v1 (
    .clk       (clk),
    .rst       (rst),
    .ctl       ('{adv: adv, valid: rr_vld}),
    .num       (sb[NSB-1].m1),
    .den       (rr_root),
    .quo_valid (div1_vld),
    .quo       (c1)
  );

  pgsg_div_pipe u_div_v2 (
    .clk       (clk),
    .rst       (rst),
    .ctl       ('{adv: adv, valid: rr_vld}),
    .num       (sb[NSB-1].m2),
    .den       (rr_root),
    .quo_valid (div2_vld),
    .quo       (c2)
  );

  // ---------------------------------------------------------------------
  // Back end: z = c * g, scale by std_dev with rounding, sign, add the
  // mean and saturate. Sample 1 comes from v1, sample 2 from v2.
  // ---------------------------------------------------------------------
  logic [63:0] z1_prod, z2_prod;
  logic [30:0] q1_z1, q1_z2;
  logic [1:0]  q1_n, q2_n;
  logic        q1_v, q2_v, q3_v;
  logic [62:0] q2_p1, q2_p2;
  logic [62:0] rnd1, rnd2;
  logic [36:0] mag1, mag2;
  logic [38:0] q3_s1, q3_s2;
  logic [39:0] sum1, sum2;
  logic [39:0] mean40;
  logic [31:0] q4_s1, q4_s2;

  assign z1_prod = {33'd0, c1} * {32'd0, g_root};
  assign z2_prod = {33'd0, c2} * {32'd0, g_root};
  assign rnd1    = q2_p1 + (63'd1 << (ZF - 1));
  assign rnd2    = q2_p2 + (63'd1 << (ZF - 1));
  assign mag1    = 37'(rnd1 >> ZF);
  assign mag2    = 37'(rnd2 >> ZF);
  assign mean40  = {{8{mean_offset[31]}}, mean_offset};
  assign sum1    = {q3_s1[38], q3_s1} + mean40;
  assign sum2    = {q3_s2[38], q3_s2} + mean40;

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_z1 <= z1_prod[60:30];
      q1_z2 <= z2_prod[60:30];
      q1_n  <= ng[NNG-1];
      q2_p1 <= 63'({33'd0, q1_z1} * {32'd0, std_dev});
      q2_p2 <= 63'({33'd0, q1_z2} * {32'd0, std_dev});
      q2_n  <= q1_n;
      q3_s1 <= q2_n[1] ? (39'd0 - {2'b00, mag1}) : {2'b00, mag1};
      q3_s2 <= q2_n[0] ? (39'd0 - {2'b00, mag2}) : {2'b00, mag2};
      q4_s1 <= sat32(sum1);
      q4_s2 <= sat32(sum2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_v <= 1'b0;
      q2_v <= 1'b0;
      q3_v <= 1'b0;
      q4_v <= 1'b0;
    end else if (adv) begin
      q1_v <= div1_vld;
      q2_v <= q1_v;
      q3_v <= q2_v;
      q4_v <= q3_v;
    end
  end

  // ---------------------------------------------------------------------
  // Output register. It holds one pair and sends the v2 sample first, then
  // the v1 sample with last set; a new pair loads as the second beat leaves.
  // ---------------------------------------------------------------------
  logic [31:0] hold_s1, hold_s2;

  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_s1 <= q4_s1;
      hold_s2 <= q4_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v     <= 1'b0;
      hold_phase <= 1'b0;
    end else if (hold_load) begin
      hold_v     <= 1'b1;
      hold_phase <= 1'b0;
    end else if (hold_v && out_ready) begin
      if (hold_phase) begin
        hold_v     <= 1'b0;
        hold_phase <= 1'b0;
      end else begin
        hold_phase <= 1'b1;
      end
    end
  end

  assign out_valid       = hold_v;
  assign out_data.sample = hold_phase ? hold_s1 : hold_s2;
  assign out_data.last   = hold_phase;

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  // The log path and the root/divide path must deliver the same item.
  `PGSG_ASSERT_NOW(a_paths_aligned, 1'b1, (g_vld == div1_vld) && (div1_vld == div2_vld))
  // A pair that has not finished leaving is never overwritten.
  `PGSG_ASSERT_NEXT(a_hold_kept, hold_v && !hold_release, hold_v && $stable(hold_s1) && $stable(hold_s2))
  // A full last stage that cannot move holds its result.
  `PGSG_ASSERT_NEXT(a_tail_kept, q4_v && !hold_load, q4_v && $stable(q4_s1) && $stable(q4_s2))
  // After the closing beat the next beat opens a new pair.
  `PGSG_ASSERT_NEXT(a_pair_closed, out_valid && out_ready && out_data.last, !hold_phase)

endmodule
